// ===== src/mmfs_pkg.sv =====
// ----------------------------------------------------------------------------
// mmfs_pkg: shared types and constants of the min-max feature scaler
// Field widths, status and action codes, sequencer states and the divider
// status bundle used by the scaler core and its sub-modules.
// ----------------------------------------------------------------------------
package mmfs_pkg;

    // default sizing
    localparam int MAX_FEATURES_DEF = 64;
    localparam int VALUE_WIDTH_DEF  = 32;

    // fixed field widths
    localparam int INDEX_WIDTH  = 6;
    localparam int INDEX_SPAN   = 2 ** INDEX_WIDTH;
    localparam int SAMPLE_WIDTH = 32;
    localparam int FRAC_BITS    = 16;
    localparam int QUOT_WIDTH   = FRAC_BITS + 1;
    localparam int STATUS_WIDTH = 2;

    // stream beat widths, padded to whole bytes
    localparam int S_TDATA_WIDTH = ((INDEX_WIDTH + SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_WIDTH = ((INDEX_WIDTH + QUOT_WIDTH + 7) / 8) * 8;

    // exactly one in unsigned q1.16
    localparam logic [QUOT_WIDTH-1:0] ONE_Q16 = {1'b1, {FRAC_BITS{1'b0}}};

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_CONSTANT  = 2'd1,
        STATUS_UNLEARNED = 2'd2,
        STATUS_CLIPPED   = 2'd3
    } status_t;

    typedef enum logic {
        ACTION_LEARN = 1'b0,
        ACTION_SCALE = 1'b1
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

// ===== src/mmfs_ram.sv =====
// ----------------------------------------------------------------------------
// mmfs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined until
// written.
// ----------------------------------------------------------------------------
module mmfs_ram #(
    parameter int WIDTH = 2 * mmfs_pkg::VALUE_WIDTH_DEF,
    parameter int DEPTH = mmfs_pkg::MAX_FEATURES_DEF
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/mmfs_div.sv =====
// ----------------------------------------------------------------------------
// mmfs_div: serial restoring divider, one quotient bit per cycle
// Forms floor(num * 2^16 / den) for num <= den as a 17-bit quotient,
// one bit per step; the first step compares without shifting.
// ----------------------------------------------------------------------------
module mmfs_div #(
    parameter int WIDTH = mmfs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [WIDTH-1:0]                   num,
    input  logic [WIDTH-1:0]                   den,
    output logic [mmfs_pkg::QUOT_WIDTH-1:0]    quotient,
    output mmfs_pkg::div_status_t              status
);

    localparam int CW = $clog2(mmfs_pkg::QUOT_WIDTH);
    localparam logic [CW-1:0] LAST_STEP = CW'(mmfs_pkg::QUOT_WIDTH - 1);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic                            first_reg;
    logic [CW-1:0]                   count_reg;
    logic [WIDTH-1:0]                rem_reg;
    logic [WIDTH-1:0]                den_reg;
    logic [mmfs_pkg::QUOT_WIDTH-1:0] quot_reg;

    logic [WIDTH:0]                  shifted;
    logic [WIDTH:0]                  diff;
    logic                            fits;
    logic [WIDTH-1:0]                rem_next;
    logic [mmfs_pkg::QUOT_WIDTH-1:0] quot_next;

    // one restoring step
    always_comb
    begin
        shifted   = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff      = shifted - {1'b0, den_reg};
        fits      = (shifted >= {1'b0, den_reg});
        rem_next  = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
        quot_next = {quot_reg[mmfs_pkg::QUOT_WIDTH-2:0], fits};
    end

    // step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
        end
        else if (busy_reg && (count_reg == LAST_STEP))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            first_reg <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (start)
            begin
                first_reg <= 1'b1;
                count_reg <= '0;
            end
            else if (busy_reg)
            begin
                first_reg <= 1'b0;
                count_reg <= count_reg + CW'(1);
            end
        end
    end

    // remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
    end

    assign quotient    = quot_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

// ===== src/min_max_feature_scaler_core.sv =====
// ----------------------------------------------------------------------------
// min_max_feature_scaler_core: per-feature min-max scaler
// Learns the range of each feature column and maps samples into 0..1.
// ----------------------------------------------------------------------------
// Input beats arrive on s_* with the action on s_tuser: a learn beat widens
// the stored minimum and maximum of its column (the first one sets both),
// a scale beat yields one result beat on m_* carrying the column, the value
// (v - min) / (max - min) as unsigned q1.16 clipped to 0..1, and a status
// on m_tuser (ok, constant column, never learned, clipped).
// A learn beat goes through the eval state, which writes the range back. A scale
// beat that needs no division goes from eval to emit; its result passes the
// pending and output registers. A scale beat that divides waits in the divide
// state for the 17-step serial restoring divider, one quotient bit a cycle.
// The range store is one RAM with a registered read, read at acceptance.
// s_tready is high only while the sequencer is idle. A finished result sits
// in an output register, so the next beat is taken while it waits; when the
// receiver stalls, a second result waits in the sequencer until it is free.
// Reset clears the seen flags and all control state; the range RAM is not
// cleared and its contents are only used for columns already learned.
// ----------------------------------------------------------------------------
module min_max_feature_scaler_core #(
    parameter int MAX_FEATURES = mmfs_pkg::MAX_FEATURES_DEF,
    parameter int VALUE_WIDTH  = mmfs_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input beats
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mmfs_pkg::S_TDATA_WIDTH-1:0]   s_tdata,  // feature_index, feature_value
    input  logic                                 s_tuser,  // action
    // result beats
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mmfs_pkg::M_TDATA_WIDTH-1:0]   m_tdata,  // feature_index_out, scaled_value
    output logic [mmfs_pkg::STATUS_WIDTH-1:0]    m_tuser   // status
);

    localparam int IW    = mmfs_pkg::INDEX_WIDTH;
    localparam int QW    = mmfs_pkg::QUOT_WIDTH;
    localparam int VW    = VALUE_WIDTH;
    localparam int SW    = mmfs_pkg::SAMPLE_WIDTH;
    localparam int DEPTH = (MAX_FEATURES < mmfs_pkg::INDEX_SPAN) ?
                           MAX_FEATURES : mmfs_pkg::INDEX_SPAN;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PAD   = mmfs_pkg::M_TDATA_WIDTH - IW - QW;
    localparam logic [IW:0] INDEX_LIMIT = (IW + 1)'(DEPTH);

    // sequencer
    mmfs_pkg::state_t      state_reg, state_next;

    // accepted item
    mmfs_pkg::action_t     act_reg;
    logic [IW-1:0]         idx_reg;
    logic [VW-1:0]         val_reg;

    // seen flags, one per column
    logic [DEPTH-1:0]      seen_reg;

    // pending result
    logic [QW-1:0]         scaled_reg;
    mmfs_pkg::status_t     status_reg;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [IW-1:0]         out_index_reg;
    logic [QW-1:0]         out_scaled_reg;
    mmfs_pkg::status_t     out_status_reg;

    // input unpacking
    logic [IW-1:0]         in_index;
    logic [SW-1:0]         in_raw;
    logic [VW+SW-1:0]      raw_ext;
    logic [VW-1:0]         in_sample;
    logic [AW+IW-1:0]      in_index_ext;
    logic [AW-1:0]         rd_addr;
    logic [AW+IW-1:0]      idx_ext;
    logic [AW-1:0]         idx_addr;

    // range lookup and decision
    logic [2*VW-1:0]       range_rd;
    logic [VW-1:0]         range_lo;
    logic [VW-1:0]         range_hi;
    logic [VW-1:0]         new_lo;
    logic [VW-1:0]         new_hi;
    logic                  index_ok;
    logic                  seen_hit;
    logic                  below;
    logic                  above;
    logic                  flat;
    logic                  need_div;
    logic [VW-1:0]         div_num;
    logic [VW-1:0]         div_den;
    logic [QW-1:0]         eval_scaled;
    mmfs_pkg::status_t     eval_status;

    // control strobes
    logic                  out_free;
    logic                  accept;
    logic                  ram_wr_en;
    logic                  div_start;
    logic                  res_load_eval;
    logic                  res_load_div;
    logic                  out_load;

    // divider
    logic [QW-1:0]         div_quot;
    mmfs_pkg::div_status_t div_stat;

    // input field extraction
    always_comb
    begin
        in_index     = s_tdata[IW-1:0];
        in_raw       = s_tdata[IW +: SW];
        raw_ext      = {{VW{1'b0}}, in_raw};
        in_sample    = raw_ext[VW-1:0];
        in_index_ext = {{AW{1'b0}}, in_index};
        rd_addr      = in_index_ext[AW-1:0];
        idx_ext      = {{AW{1'b0}}, idx_reg};
        idx_addr     = idx_ext[AW-1:0];
    end

    // range evaluation on the registered ram read
    always_comb
    begin
        range_lo    = range_rd[VW-1:0];
        range_hi    = range_rd[2*VW-1:VW];
        index_ok    = ({1'b0, idx_reg} < INDEX_LIMIT);
        seen_hit    = index_ok && seen_reg[idx_addr];
        below       = ($signed(val_reg) < $signed(range_lo));
        above       = ($signed(val_reg) > $signed(range_hi));
        flat        = (range_lo == range_hi);
        new_lo      = (!seen_hit || below) ? val_reg : range_lo;
        new_hi      = (!seen_hit || above) ? val_reg : range_hi;
        div_num     = val_reg - range_lo;
        div_den     = range_hi - range_lo;
        need_div    = 1'b0;
        eval_scaled = '0;
        eval_status = mmfs_pkg::STATUS_OK;
        priority if (!seen_hit)
        begin
            eval_status = mmfs_pkg::STATUS_UNLEARNED;
        end
        else if (flat)
        begin
            eval_status = mmfs_pkg::STATUS_CONSTANT;
        end
        else if (below)
        begin
            eval_status = mmfs_pkg::STATUS_CLIPPED;
        end
        else if (above)
        begin
            eval_scaled = mmfs_pkg::ONE_Q16;
            eval_status = mmfs_pkg::STATUS_CLIPPED;
        end
        else
        begin
            need_div = 1'b1;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mmfs_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = mmfs_pkg::ST_EVAL;
                end
            end
            mmfs_pkg::ST_EVAL:
            begin
                if (act_reg == mmfs_pkg::ACTION_LEARN)
                begin
                    state_next = mmfs_pkg::ST_IDLE;
                end
                else if (need_div)
                begin
                    state_next = mmfs_pkg::ST_DIVIDE;
                end
                else
                begin
                    state_next = mmfs_pkg::ST_EMIT;
                end
            end
            mmfs_pkg::ST_DIVIDE:
            begin
                if (div_stat.done)
                begin
                    state_next = mmfs_pkg::ST_EMIT;
                end
            end
            mmfs_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = mmfs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mmfs_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready      = 1'b0;
        ram_wr_en     = 1'b0;
        div_start     = 1'b0;
        res_load_eval = 1'b0;
        res_load_div  = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            mmfs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            mmfs_pkg::ST_EVAL:
            begin
                if (act_reg == mmfs_pkg::ACTION_LEARN)
                begin
                    ram_wr_en = index_ok;
                end
                else
                begin
                    div_start     = need_div;
                    res_load_eval = !need_div;
                end
            end
            mmfs_pkg::ST_DIVIDE:
            begin
                res_load_div = div_stat.done;
            end
            mmfs_pkg::ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // output valid tracking
    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= mmfs_pkg::ST_IDLE;
            m_tvalid_reg <= 1'b0;
            seen_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (ram_wr_en)
            begin
                seen_reg[idx_addr] <= 1'b1;
            end
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg <= mmfs_pkg::action_t'(s_tuser);
            idx_reg <= in_index;
            val_reg <= in_sample;
        end
    end

    // pending result
    always_ff @(posedge clk)
    begin
        if (res_load_eval)
        begin
            scaled_reg <= eval_scaled;
            status_reg <= eval_status;
        end
        else if (res_load_div)
        begin
            scaled_reg <= div_quot;
            status_reg <= mmfs_pkg::STATUS_OK;
        end
    end

    // output register
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_index_reg  <= idx_reg;
            out_scaled_reg <= scaled_reg;
            out_status_reg <= status_reg;
        end
    end

    // range store, {max, min} per column
    mmfs_ram #(
        .WIDTH (2 * VW),
        .DEPTH (DEPTH)
    ) u_range_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (idx_addr),
        .wr_data ({new_hi, new_lo}),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (range_rd)
    );

    // serial divider
    mmfs_div #(
        .WIDTH (VW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .num      (div_num),
        .den      (div_den),
        .quotient (div_quot),
        .status   (div_stat)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD{1'b0}}, out_scaled_reg, out_index_reg};
    assign m_tuser  = out_status_reg;

    // divider only runs while the sequencer waits for it
    a_div_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == mmfs_pkg::ST_DIVIDE))
        else $error("divider busy outside divide state");

    // a new result beat only comes from the emit state
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> ($past(state_reg) == mmfs_pkg::ST_EMIT))
        else $error("result beat raised outside emit state");

    // scaled value never exceeds one
    a_scaled_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid_reg |-> (out_scaled_reg <= mmfs_pkg::ONE_Q16))
        else $error("scaled value above one");

    // unlearned and constant columns report zero
    a_zero_cases: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && ((out_status_reg == mmfs_pkg::STATUS_UNLEARNED) ||
                          (out_status_reg == mmfs_pkg::STATUS_CONSTANT)))
        |-> (out_scaled_reg == '0))
        else $error("nonzero value for unlearned or constant column");

    // seen flags are never cleared after reset
    a_seen_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (($past(seen_reg) & ~seen_reg) == '0))
        else $error("seen flag cleared");

endmodule
